// ===== sv/mcfa_pkg.sv =====
package mcfa_pkg;

  // Defaults for the top-level parameters
  localparam int MCFA_MAX_CHANNELS = 8;
  localparam int MCFA_QUEUE_DEPTH  = 8;

  // Hard cap on slots; the channel field is 3 bits wide
  localparam int SLOT_CAP = 8;

  // Payload widths
  localparam int CH_W    = 3;
  localparam int TAG_W   = 32;
  localparam int TS_W    = 48;
  localparam int ENTRY_W = TAG_W + TS_W;
  localparam int DATA_W  = 88;  // 83 payload bits padded to whole bytes

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_NUM_CHANNELS = 3'd0,
    REG_ORDER_MODE   = 3'd1,
    REG_PACKAGE_MODE = 3'd2,
    REG_QUEUE_LIMIT  = 3'd3,
    REG_MAX_TS_DIFF  = 3'd4,
    REG_RUNNING      = 3'd5
  } reg_idx_e;

  localparam logic [3:0] NUM_CHANNELS_RST = 4'd1;
  localparam logic [3:0] QUEUE_LIMIT_RST  = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TRIM,
    ST_PUSH,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SPREAD,
    ST_DROP,
    ST_RR_SCAN,
    ST_EMIT_RD,
    ST_EMIT,
    ST_PASS
  } state_e;

endpackage

// ===== sv/multi_channel_frame_aligner_unit.sv =====
// Pass-through path: input registers, dispatch state, pass state, then the output register.
// Ordering path: dispatch, trim (pops until below the limit), push; bundle mode then check,
//   scan (read and compare per active slot), spread, then read and emit per frame or drop the
//   set slot by slot; round-robin scans slots, then reads and emits each eligible frame.
// Output stalls stretch each emit and pass step. One frame in flight: ready only when idle.
// Reset (async, low): queues empty, send flags open, registers at defaults; store not cleared.
module multi_channel_frame_aligner_unit #(
  parameter int MAX_CHANNELS = mcfa_pkg::MCFA_MAX_CHANNELS,
  parameter int QUEUE_DEPTH  = mcfa_pkg::MCFA_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Frame in: tdata from bit 0 up = channel[2:0], frame_tag[31:0], timestamp[47:0], pad[4:0]
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mcfa_pkg::DATA_W-1:0] s_axis_tdata,
  // Frame out: tdata from bit 0 up = out_channel[2:0], out_tag[31:0], out_timestamp[47:0],
  //   pad[4:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mcfa_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  // Register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcfa_pkg::APB_AW-1:0] paddr,
  input  logic [mcfa_pkg::APB_DW-1:0] pwdata,
  output logic [mcfa_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import mcfa_pkg::*;

  // Slots that can ever be active; queue storage sized from it
  localparam int NSLOT = (MAX_CHANNELS < SLOT_CAP) ? MAX_CHANNELS : SLOT_CAP;
  localparam int SW    = $clog2(NSLOT);
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int MD    = NSLOT * QUEUE_DEPTH;
  localparam int AW    = $clog2(MD);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0]  cfg_nch_q, cfg_qlim_q;
  logic        cfg_order_q, cfg_pkg_q, cfg_run_q;
  logic [30:0] cfg_maxd_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nch_q   <= NUM_CHANNELS_RST;
      cfg_order_q <= 1'b0;
      cfg_pkg_q   <= 1'b0;
      cfg_qlim_q  <= QUEUE_LIMIT_RST;
      cfg_maxd_q  <= '0;
      cfg_run_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUM_CHANNELS: cfg_nch_q   <= pwdata[3:0];
        REG_ORDER_MODE:   cfg_order_q <= pwdata[0];
        REG_PACKAGE_MODE: cfg_pkg_q   <= pwdata[0];
        REG_QUEUE_LIMIT:  cfg_qlim_q  <= pwdata[3:0];
        REG_MAX_TS_DIFF:  cfg_maxd_q  <= pwdata[30:0];
        REG_RUNNING:      cfg_run_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_NUM_CHANNELS: prdata = {28'd0, cfg_nch_q};
      REG_ORDER_MODE:   prdata = {31'd0, cfg_order_q};
      REG_PACKAGE_MODE: prdata = {31'd0, cfg_pkg_q};
      REG_QUEUE_LIMIT:  prdata = {28'd0, cfg_qlim_q};
      REG_MAX_TS_DIFF:  prdata = {1'b0, cfg_maxd_q};
      REG_RUNNING:      prdata = {31'd0, cfg_run_q};
      default:          prdata = '0;
    endcase
  end

  // Effective channel count (0 acts as 1, saturate to slot count)
  logic [3:0]    n_act;
  logic [CW-1:0] lim;

  always_comb begin
    if (cfg_nch_q == 4'd0) begin
      n_act = 4'd1;
    end else if (32'(cfg_nch_q) > NSLOT) begin
      n_act = 4'(NSLOT);
    end else begin
      n_act = cfg_nch_q;
    end
    if (cfg_qlim_q == 4'd0) begin
      lim = CW'(1);
    end else if (32'(cfg_qlim_q) > QUEUE_DEPTH) begin
      lim = CW'(QUEUE_DEPTH);
    end else begin
      lim = CW'(cfg_qlim_q);
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [CH_W-1:0]  in_ch_q;
  logic [TAG_W-1:0] in_tag_q;
  logic [TS_W-1:0]  in_ts_q;

  logic [HW-1:0]    head_q  [NSLOT];
  logic [CW-1:0]    count_q [NSLOT];
  logic [NSLOT-1:0] open_q;
  logic [SW-1:0]    slot_q;
  logic [TS_W-1:0]  lo_q, hi_q;

  logic [ENTRY_W-1:0] mem [MD];
  logic [ENTRY_W-1:0] rd_q;

  logic             m_valid_q, m_last_q;
  logic [CH_W-1:0]  m_ch_q;
  logic [TAG_W-1:0] m_tag_q;
  logic [TS_W-1:0]  m_ts_q;

  // Per-slot status
  logic [NSLOT-1:0] active, nonempty, elig, elig_above;

  always_comb begin
    for (int s = 0; s < NSLOT; s++) begin
      active[s]     = 4'(s) < n_act;
      nonempty[s]   = count_q[s] != '0;
      elig[s]       = active[s] && nonempty[s] && open_q[s];
      elig_above[s] = elig[s] && (s > int'(slot_q));
    end
  end

  // Shared queue datapath: one slot handled per cycle
  logic [SW-1:0]   cur_slot;
  logic [HW-1:0]   cur_head, head_inc, push_pos;
  logic [CW-1:0]   cur_count;
  logic [CW:0]     pos_sum;
  logic [AW-1:0]   base, rd_addr, wr_addr;

  assign cur_slot  = (state_q == ST_TRIM || state_q == ST_PUSH) ? in_ch_q[SW-1:0] : slot_q;
  assign cur_head  = head_q[cur_slot];
  assign cur_count = count_q[cur_slot];
  assign head_inc  = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + HW'(1);
  assign pos_sum   = (CW+1)'(cur_head) + (CW+1)'(cur_count);
  assign push_pos  = (pos_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     HW'(pos_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);
  assign base      = AW'(cur_slot) * AW'(QUEUE_DEPTH);
  assign rd_addr   = base + AW'(cur_head);
  assign wr_addr   = base + AW'(push_pos);

  // Decisions
  logic passthru, ch_bad, missing, last_slot, spread_bad, reopen, emit_last, out_free;
  logic [TS_W-1:0] rd_ts;

  assign rd_ts      = rd_q[ENTRY_W-1:TAG_W];
  assign passthru   = (n_act <= 4'd1) || !cfg_order_q;
  assign ch_bad     = {1'b0, in_ch_q} >= n_act;
  assign missing    = |(active & ~nonempty);
  assign last_slot  = 4'(slot_q) == (n_act - 4'd1);
  assign spread_bad = (cfg_maxd_q != '0) && ((hi_q - lo_q) > TS_W'(cfg_maxd_q));
  assign reopen     = (open_q & active) == '0;
  assign emit_last  = cfg_pkg_q ? last_slot : ~|elig_above;
  assign out_free   = !m_valid_q || m_axis_tready;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (passthru) begin
          state_d = ST_PASS;
        end else if (!cfg_run_q || ch_bad) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM:     if (cur_count < lim) state_d = ST_PUSH;
      ST_PUSH:     state_d = cfg_pkg_q ? ST_CHECK : ST_RR_SCAN;
      ST_CHECK:    state_d = missing ? ST_IDLE : ST_SCAN_RD;
      ST_SCAN_RD:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = last_slot ? ST_SPREAD : ST_SCAN_RD;
      ST_SPREAD:   state_d = spread_bad ? ST_DROP : ST_EMIT_RD;
      ST_DROP:     if (last_slot) state_d = ST_IDLE;
      ST_RR_SCAN: begin
        if (elig[slot_q]) begin
          state_d = ST_EMIT_RD;
        end else if (last_slot) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = cfg_pkg_q ? ST_EMIT_RD : ST_RR_SCAN;
          end
        end
      end
      ST_PASS:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------------
  logic flush, pop_en, push_en, rd_en, out_load, out_pass, reopen_set, close_open;
  logic slot_clr, slot_inc, lohi_init, lohi_upd;

  always_comb begin
    s_axis_tready = 1'b0;
    flush         = 1'b0;
    pop_en        = 1'b0;
    push_en       = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    out_pass      = 1'b0;
    reopen_set    = 1'b0;
    close_open    = 1'b0;
    slot_clr      = 1'b0;
    slot_inc      = 1'b0;
    lohi_init     = 1'b0;
    lohi_upd      = 1'b0;
    case (state_q)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_DISPATCH: flush = !passthru && !cfg_run_q;
      ST_TRIM:     pop_en = cur_count >= lim;
      ST_PUSH: begin
        push_en    = 1'b1;
        reopen_set = !cfg_pkg_q && reopen;
        slot_clr   = 1'b1;
      end
      ST_CHECK: begin
        slot_clr  = 1'b1;
        lohi_init = 1'b1;
      end
      ST_SCAN_RD:  rd_en = 1'b1;
      ST_SCAN_CMP: begin
        lohi_upd = 1'b1;
        slot_inc = !last_slot;
        slot_clr = last_slot;
      end
      ST_DROP: begin
        pop_en   = 1'b1;
        slot_inc = !last_slot;
      end
      ST_RR_SCAN:  slot_inc = !elig[slot_q] && !last_slot;
      ST_EMIT_RD:  rd_en = 1'b1;
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          pop_en     = 1'b1;
          close_open = !cfg_pkg_q;
          slot_inc   = !emit_last;
        end
      end
      ST_PASS: begin
        out_load = out_free;
        out_pass = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      open_q  <= '1;
      for (int s = 0; s < NSLOT; s++) begin
        head_q[s]  <= '0;
        count_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (slot_clr) begin
        slot_q <= '0;
      end else if (slot_inc) begin
        slot_q <= slot_q + SW'(1);
      end
      if (reopen_set) begin
        open_q <= '1;
      end else if (close_open) begin
        open_q[slot_q] <= 1'b0;
      end
      if (flush) begin
        for (int s = 0; s < NSLOT; s++) begin
          head_q[s]  <= '0;
          count_q[s] <= '0;
        end
      end else if (pop_en) begin
        head_q[cur_slot]  <= head_inc;
        count_q[cur_slot] <= cur_count - CW'(1);
      end else if (push_en) begin
        count_q[cur_slot] <= cur_count + CW'(1);
      end
    end
  end

  // Input capture and spread tracking (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q  <= s_axis_tdata[CH_W-1:0];
      in_tag_q <= s_axis_tdata[CH_W+TAG_W-1:CH_W];
      in_ts_q  <= s_axis_tdata[CH_W+TAG_W+TS_W-1:CH_W+TAG_W];
    end
    if (lohi_init) begin
      lo_q <= '1;
      hi_q <= '0;
    end else if (lohi_upd) begin
      if (rd_ts < lo_q) lo_q <= rd_ts;
      if (rd_ts > hi_q) hi_q <= rd_ts;
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[wr_addr] <= {in_ts_q, in_tag_q};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (out_pass) begin
        m_ch_q   <= in_ch_q;
        m_tag_q  <= in_tag_q;
        m_ts_q   <= in_ts_q;
        m_last_q <= 1'b1;
      end else begin
        m_ch_q   <= CH_W'(slot_q);
        m_tag_q  <= rd_q[TAG_W-1:0];
        m_ts_q   <= rd_ts;
        m_last_q <= emit_last;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_ts_q, m_tag_q, m_ch_q};
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A result is never loaded over one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

  // Trim loop leaves room below the limit before the push
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (cur_count < lim))
    else $error("push into full queue");

  // The pushed queue holds at least one entry afterwards
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |=> (count_q[$past(cur_slot)] != '0))
    else $error("queue empty after push");

  // Spread bounds are ordered once the scan is complete
  a_spread_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPREAD) |-> (lo_q <= hi_q))
    else $error("timestamp bounds inverted");

endmodule
